/* sv/iinav_pkg.sv */
// shared constants, types and helper functions of the image index navigator
// no dependencies; imported by every other file of the block except iinav_ram
`default_nettype none

package iinav_pkg;

	localparam int MAX_IMAGES = 4096;
	localparam int IDX_W      = $clog2(MAX_IMAGES);
	localparam int CNT_W      = IDX_W + 1;
	localparam int SEED_W     = 16;
	localparam int PROD_W     = SEED_W + CNT_W;

	localparam int S_DATA_W   = 16;
	localparam int M_DATA_W   = 16;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [SEED_W-1:0] LFSR_TAPS    = 16'hB400;
	localparam logic [CNT_W-1:0]  CURSOR_EMPTY = '1;

	typedef enum logic [1:0] {
		REQ_STEP = 2'd0,
		REQ_FWD  = 2'd1,
		REQ_BACK = 2'd2,
		REQ_TO   = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		REG_COUNT  = 2'd0,
		REG_RANDOM = 2'd1,
		REG_SEED   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		req_type_t        req_type;
		logic [1:0]       step_dir;
		logic [CNT_W-1:0] jump_amount;
	} nav_req_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] image_index;
		logic             ignored;
	} nav_rsp_t;

	typedef struct packed {
		logic              count_wr;
		logic              seed_wr;
		logic [SEED_W-1:0] seed;
	} cfg_evt_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] remainder;
	} rem_rsp_t;

	// zero acts as one, anything above the store depth acts as the depth
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = c;
		if (c == '0)
			r = CNT_W'(1);
		else if (c > CNT_W'(MAX_IMAGES))
			r = CNT_W'(MAX_IMAGES);
		return r;
	endfunction

	// galois shift to the right
	function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
		logic [SEED_W-1:0] r;
		r = {1'b0, v[SEED_W-1:1]};
		if (v[0])
			r = r ^ LFSR_TAPS;
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/image_index_navigator_with_shuffle_core.sv */
// top level: apb register file, input stream, output register, sequencer
// depends on iinav_pkg and iinav_seq (which holds iinav_ram and iinav_rem)
`default_nettype none

// Keeps a current image index among image_count entries and answers every
// request item with one result item carrying the new index and an ignored
// flag. One item is in work at a time. Jumps and sequential steps from an
// index inside the count pass the execute and done states and the output
// register; the next item may be accepted at the same edge as the earliest
// result handshake. A sequential step whose wrap needs a true modulo (index
// a full count or more beyond a shrunken count) goes through the bit-serial
// remainder unit. A random-order step pops the stored permutation; when it
// is empty it is first rebuilt: the store is filled in order, then each entry
// is swapped with a drawn one in shuffle states A, B and C (one memory write
// port). Writing image_count empties the permutation; writing rng_seed
// reloads the shuffle generator. Registers are to be written by the user
// only while no item is in work; the block itself does not enforce this.

module image_index_navigator_with_shuffle_core
	import iinav_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// apb configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	// request items
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_DATA_W-1:0]   s_tdata,   // step_dir[1:0], jump_amount[14:2], zero pad
	input  wire logic [1:0]            s_tuser,   // req_type[1:0]
	// result items
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [M_DATA_W-1:0]   m_tdata,   // image_index[11:0], zero pad
	output logic      [0:0]            m_tuser    // ignored[0]
);

	logic [CNT_W-1:0]  count_q;
	logic              random_q;
	logic [SEED_W-1:0] seed_q;
	logic              apb_wr;
	reg_idx_t          reg_idx;
	cfg_evt_t          cfg;

	nav_req_t          req;
	nav_rsp_t          rsp;
	logic              start;
	logic              seq_idle;
	logic              rsp_take;

	logic              m_valid_q;
	logic [IDX_W-1:0]  m_index_q;
	logic              m_ign_q;

	assign pready  = 1'b1;
	assign apb_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= CNT_W'(1);
			random_q <= 1'b0;
			seed_q   <= SEED_W'(1);
		end else if (apb_wr) begin
			case (reg_idx)
				REG_COUNT:  count_q  <= pwdata[CNT_W-1:0];
				REG_RANDOM: random_q <= pwdata[0];
				REG_SEED:   seed_q   <= pwdata[SEED_W-1:0];
				default:    count_q  <= count_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_COUNT:  prdata = APB_DATA_W'(count_q);
			REG_RANDOM: prdata = APB_DATA_W'(random_q);
			REG_SEED:   prdata = APB_DATA_W'(seed_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.count_wr = apb_wr && (reg_idx == REG_COUNT);
	assign cfg.seed_wr  = apb_wr && (reg_idx == REG_SEED);
	assign cfg.seed     = pwdata[SEED_W-1:0];

	assign s_tready        = seq_idle;
	assign start           = s_tvalid && s_tready;
	assign req.req_type    = req_type_t'(s_tuser);
	assign req.step_dir    = s_tdata[1:0];
	assign req.jump_amount = s_tdata[CNT_W+1:2];

	iinav_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req          (req),
		.image_count  (count_q),
		.shuffle_on   (random_q),
		.cfg          (cfg),
		.idle         (seq_idle),
		.rsp          (rsp),
		.rsp_take     (rsp_take)
	);

	// output register frees the sequencer while a result waits downstream
	assign rsp_take = rsp.valid && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (rsp_take)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rsp_take) begin
			m_index_q <= rsp.image_index;
			m_ign_q   <= rsp.ignored;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(M_DATA_W - IDX_W)'(0), m_index_q};
	assign m_tuser  = m_ign_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted again right after an item was taken");

	a_no_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !s_tready)
		else $error("input ready while a result is still held in the sequencer");

	a_output_from_take: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(rsp_take))
		else $error("result item appeared without a transfer from the sequencer");
`endif

endmodule

`default_nettype wire

/* sv/iinav_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// write-first: a read of the address being written returns the new data
`default_nettype none

module iinav_ram #(
	parameter  int DEPTH = 4096,
	parameter  int WIDTH = 12,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (we && (waddr == raddr))
			rdata <= wdata;
		else
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* sv/iinav_rem.sv */
// iterative restoring remainder unit, one dividend bit per cycle
// depends on iinav_pkg
`default_nettype none

module iinav_rem
	import iinav_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire rem_req_t req,
	output rem_rsp_t      rsp
);

	localparam int CNT_BITS = $clog2(CNT_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [CNT_W-1:0]    dvd_q;
	logic [CNT_W-1:0]    dsr_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W:0]      trial;

	assign trial = {rem_q, dvd_q[CNT_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(CNT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[CNT_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q})
				rem_q <= CNT_W'(trial - {1'b0, dsr_q});
			else
				rem_q <= trial[CNT_W-1:0];
		end
	end

	// remainder is below the divisor, which never exceeds the store depth
	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q[IDX_W-1:0];

endmodule

`default_nettype wire

/* sv/iinav_seq.sv */
// request sequencer: index arithmetic, permutation store, shuffle and pop
// depends on iinav_pkg, iinav_ram, iinav_rem
`default_nettype none

module iinav_seq
	import iinav_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire nav_req_t         req,
	input  wire logic [CNT_W-1:0] image_count,
	input  wire logic             shuffle_on,
	input  wire cfg_evt_t         cfg,
	output logic                  idle,
	output nav_rsp_t              rsp,
	input  wire logic             rsp_take
);

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b0000000001,
		ST_EXEC     = 10'b0000000010,
		ST_REM      = 10'b0000000100,
		ST_FILL     = 10'b0000001000,
		ST_SHUF_A   = 10'b0000010000,
		ST_SHUF_B   = 10'b0000100000,
		ST_SHUF_C   = 10'b0001000000,
		ST_SHUF_END = 10'b0010000000,
		ST_POP      = 10'b0100000000,
		ST_DONE     = 10'b1000000000
	} seq_state_t;

	seq_state_t        state_q;
	nav_req_t          req_q;
	logic [IDX_W-1:0]  cur_q;
	logic              back_q;
	logic              ignored_q;
	logic [CNT_W-1:0]  cursor_q;
	logic [SEED_W-1:0] lfsr_q;
	logic              wpend_q;
	logic [IDX_W-1:0]  ctr_q;
	logic [IDX_W-1:0]  p_q;
	logic [IDX_W-1:0]  vn_q;
	logic [PROD_W-1:0] prod_s1;

	logic [CNT_W-1:0]  count;
	logic [IDX_W-1:0]  count_m1;
	logic [CNT_W-1:0]  cur_ext;
	logic              dir_back;
	logic [CNT_W-1:0]  seq_val;
	logic [CNT_W-1:0]  seq_sub;
	logic [CNT_W:0]    fwd_sum;
	logic [IDX_W-1:0]  fwd_idx;
	logic [IDX_W-1:0]  back_idx;
	logic              to_bad;
	logic              need_rebuild;
	logic [SEED_W-1:0] lfsr_nx;
	logic [CNT_W-1:0]  span;
	logic [CNT_W-1:0]  p_sum;
	logic [IDX_W-1:0]  p_next;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [IDX_W-1:0]  ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [IDX_W-1:0]  ram_rdata;

	rem_req_t          rem_req;
	rem_rsp_t          rem_rsp;

	assign count    = eff_count(image_count);
	assign count_m1 = IDX_W'(count - 1'b1);
	assign cur_ext  = {1'b0, cur_q};

	assign dir_back = (req_q.step_dir != 2'b00) ? req_q.step_dir[1] : back_q;
	assign seq_val  = dir_back ? CNT_W'(cur_ext + count - CNT_W'(1)) : CNT_W'(cur_ext + 1'b1);
	// one subtraction covers every wrap from an index inside the count
	assign seq_sub  = seq_val - count;

	assign fwd_sum  = {1'b0, cur_ext} + {1'b0, req_q.jump_amount};
	assign fwd_idx  = (fwd_sum >= {1'b0, count}) ? count_m1 : fwd_sum[IDX_W-1:0];
	assign back_idx = (cur_ext < req_q.jump_amount) ? '0 : IDX_W'(cur_ext - req_q.jump_amount);
	assign to_bad   = (req_q.jump_amount == '0) || (req_q.jump_amount > count);

	assign need_rebuild = (cursor_q == CURSOR_EMPTY) || (cursor_q >= count);

	// shuffle draw p = n + ((r * (count - n)) >> 16)
	assign lfsr_nx = lfsr_step(lfsr_q);
	assign span    = count - {1'b0, ctr_q};
	assign p_sum   = {1'b0, ctr_q} + prod_s1[PROD_W-1:SEED_W];
	assign p_next  = (p_sum >= count) ? count_m1 : p_sum[IDX_W-1:0];

	// wrap of a sequential step goes to the remainder unit only when needed
	assign rem_req.start    = (state_q == ST_EXEC) && (req_q.req_type == REQ_STEP) &&
	                          !shuffle_on && (seq_val >= count) && (seq_sub >= count);
	assign rem_req.dividend = seq_val;
	assign rem_req.divisor  = count;

	// swap of entry n with p: the write of p is deferred into the next draw, or into ST_SHUF_END after the last
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = p_q;
		ram_wdata = vn_q;
		ram_raddr = cursor_q[IDX_W-1:0];
		case (state_q)
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = ctr_q;
				ram_wdata = ctr_q;
			end
			ST_SHUF_A: begin
				ram_we    = wpend_q;
				ram_raddr = ctr_q;
			end
			ST_SHUF_B: begin
				ram_raddr = p_next;
			end
			ST_SHUF_C: begin
				ram_we    = 1'b1;
				ram_waddr = ctr_q;
				ram_wdata = ram_rdata;
			end
			ST_SHUF_END: begin
				ram_we    = 1'b1;
				ram_raddr = count_m1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_q     <= '0;
			back_q    <= 1'b0;
			ignored_q <= 1'b0;
			cursor_q  <= CURSOR_EMPTY;
			lfsr_q    <= SEED_W'(1);
			wpend_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					ignored_q <= 1'b0;
					state_q   <= ST_DONE;
					case (req_q.req_type)
						REQ_STEP: begin
							back_q <= dir_back;
							if (shuffle_on) begin
								state_q <= need_rebuild ? ST_FILL : ST_POP;
							end else if (seq_val < count) begin
								cur_q <= seq_val[IDX_W-1:0];
							end else if (seq_sub < count) begin
								cur_q <= seq_sub[IDX_W-1:0];
							end else begin
								state_q <= ST_REM;
							end
						end
						REQ_FWD: begin
							cur_q <= fwd_idx;
						end
						REQ_BACK: begin
							cur_q <= back_idx;
						end
						REQ_TO: begin
							if (to_bad)
								ignored_q <= 1'b1;
							else
								cur_q <= IDX_W'(req_q.jump_amount - 1'b1);
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_REM: begin
					if (rem_rsp.done) begin
						cur_q   <= rem_rsp.remainder;
						state_q <= ST_DONE;
					end
				end
				ST_FILL: begin
					wpend_q <= 1'b0;
					if (ctr_q == count_m1)
						state_q <= ST_SHUF_A;
				end
				ST_SHUF_A: begin
					lfsr_q  <= lfsr_nx;
					wpend_q <= 1'b0;
					state_q <= ST_SHUF_B;
				end
				ST_SHUF_B: begin
					state_q <= ST_SHUF_C;
				end
				ST_SHUF_C: begin
					wpend_q <= 1'b1;
					state_q <= (ctr_q == count_m1) ? ST_SHUF_END : ST_SHUF_A;
				end
				ST_SHUF_END: begin
					wpend_q  <= 1'b0;
					cursor_q <= {1'b0, count_m1};
					state_q  <= ST_POP;
				end
				ST_POP: begin
					cur_q    <= ram_rdata;
					cursor_q <= (cursor_q == '0) ? CURSOR_EMPTY : cursor_q - 1'b1;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_take)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// the user must write registers only while idle; the sequencer does not enforce it
			if (cfg.count_wr)
				cursor_q <= CURSOR_EMPTY;
			if (cfg.seed_wr)
				lfsr_q <= (cfg.seed == '0) ? SEED_W'(1) : cfg.seed;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start)
			req_q <= req;
		case (state_q)
			ST_EXEC: begin
				ctr_q <= '0;
			end
			ST_FILL: begin
				ctr_q <= (ctr_q == count_m1) ? '0 : ctr_q + 1'b1;
			end
			ST_SHUF_A: begin
				prod_s1 <= PROD_W'(lfsr_nx) * PROD_W'(span);
			end
			ST_SHUF_B: begin
				vn_q <= ram_rdata;
				p_q  <= p_next;
			end
			ST_SHUF_C: begin
				ctr_q <= ctr_q + 1'b1;
			end
			default: begin
				vn_q <= vn_q;
			end
		endcase
	end

	iinav_ram #(
		.DEPTH (MAX_IMAGES),
		.WIDTH (IDX_W)
	) u_perm_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	iinav_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	assign idle            = (state_q == ST_IDLE);
	assign rsp.valid       = (state_q == ST_DONE);
	assign rsp.image_index = cur_q;
	assign rsp.ignored     = ignored_q;

endmodule

`default_nettype wire

/* bench/iinav_index_checker.sv */
// result checker for the image index navigator: watches the apb port and both item streams,
// predicts every result from its own copy of the registers and state, compares field by field
// depends on iinav_pkg for widths, request and register codes, shuffle constants

module iinav_index_checker
	import iinav_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic [APB_DATA_W-1:0] prdata,
	input  logic                  pready,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,   // step_dir[1:0], jump_amount[14:2], zero pad
	input  logic [1:0]            s_tuser,   // req_type[1:0]
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_DATA_W-1:0]   m_tdata,   // image_index[11:0], zero pad
	input  logic [0:0]            m_tuser,   // ignored[0]
	output int                    mismatches,
	output int                    awaiting
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic             ignored;
	} nav_result_t;

	logic [CNT_W-1:0]  cfg_count;
	logic              cfg_random;
	logic [SEED_W-1:0] cfg_seed;

	int                pos;
	logic              heading_back;
	logic [IDX_W-1:0]  shuffle_order [MAX_IMAGES];
	logic [CNT_W-1:0]  cursor;
	logic [SEED_W-1:0] lfsr;

	nav_result_t       expected_q [$];
	nav_result_t       oldest;
	logic [APB_DATA_W-1:0] reg_val;

	task automatic flag_mismatch(input string what);
		$display("%0t ns: %s", $time, what);
		mismatches++;
	endtask

	// fill 0..cnt-1 then fisher-yates swaps driven by the galois lfsr
	function automatic void reshuffle(input int cnt);
		longint unsigned r;
		int p;
		logic [IDX_W-1:0] t;
		for (int m = 0; m < cnt; m++)
			shuffle_order[m] = IDX_W'(m);
		for (int n = 0; n < cnt; n++) begin
			lfsr = {1'b0, lfsr[SEED_W-1:1]} ^ (lfsr[0] ? LFSR_TAPS : '0);
			r = lfsr;
			p = n + int'((r * longint'(cnt - n)) >> 16);
			if (p >= cnt)
				p = cnt - 1;
			t = shuffle_order[n];
			shuffle_order[n] = shuffle_order[p];
			shuffle_order[p] = t;
		end
		cursor = CNT_W'(cnt - 1);
	endfunction

	function automatic nav_result_t navigate(input req_type_t kind, input logic [1:0] dir,
			input logic [CNT_W-1:0] amt);
		int cnt;
		int a;
		nav_result_t res;
		cnt = (cfg_count == '0) ? 1 : (cfg_count > MAX_IMAGES) ? MAX_IMAGES : int'(cfg_count);
		a = int'(amt);
		res.ignored = 1'b0;
		case (kind)
			REQ_STEP: begin
				if (dir != 2'b00)
					heading_back = dir[1];
				if (cfg_random) begin
					if (cursor == CURSOR_EMPTY || cursor >= cnt)
						reshuffle(cnt);
					pos = int'(shuffle_order[cursor[IDX_W-1:0]]);
					if (cursor == '0)
						cursor = CURSOR_EMPTY;
					else
						cursor = cursor - 1'b1;
				end else if (heading_back) begin
					pos = (pos + cnt - 1) % cnt;
				end else begin
					pos = (pos + 1) % cnt;
				end
			end
			REQ_FWD: begin
				if (pos + a > cnt - 1)
					pos = cnt - 1;
				else
					pos = pos + a;
			end
			REQ_BACK: begin
				if (pos < a)
					pos = 0;
				else
					pos = pos - a;
			end
			default: begin
				if (a < 1 || a > cnt)
					res.ignored = 1'b1;
				else
					pos = a - 1;
			end
		endcase
		res.index = IDX_W'(pos);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count    = CNT_W'(1);
			cfg_random   = 1'b0;
			cfg_seed     = SEED_W'(1);
			pos          = 0;
			heading_back = 1'b0;
			cursor       = CURSOR_EMPTY;
			lfsr         = SEED_W'(1);
			expected_q.delete();
			awaiting     = 0;
			mismatches   = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_idx_t'(paddr[3:2]))
						REG_COUNT: begin
							cfg_count = pwdata[CNT_W-1:0];
							cursor    = CURSOR_EMPTY;
						end
						REG_RANDOM: cfg_random = pwdata[0];
						REG_SEED: begin
							cfg_seed = pwdata[SEED_W-1:0];
							lfsr     = (cfg_seed == '0) ? SEED_W'(1) : cfg_seed;
						end
						default: ;
					endcase
				end else begin
					case (reg_idx_t'(paddr[3:2]))
						REG_COUNT:  reg_val = APB_DATA_W'(cfg_count);
						REG_RANDOM: reg_val = APB_DATA_W'(cfg_random);
						REG_SEED:   reg_val = APB_DATA_W'(cfg_seed);
						default:    reg_val = prdata;
					endcase
					if (prdata !== reg_val)
						flag_mismatch($sformatf("read at 0x%0h gave 0x%0h, want 0x%0h",
							paddr, prdata, reg_val));
				end
			end
			// results first: a result never belongs to the item accepted at the same edge
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					flag_mismatch($sformatf("result index %0d ignored %0b with none pending",
						m_tdata[IDX_W-1:0], m_tuser[0]));
				end else begin
					oldest = expected_q.pop_front();
					if (m_tdata[IDX_W-1:0] !== oldest.index)
						flag_mismatch($sformatf("image_index %0d, want %0d",
							m_tdata[IDX_W-1:0], oldest.index));
					if (m_tuser[0] !== oldest.ignored)
						flag_mismatch($sformatf("ignored %0b, want %0b (index %0d)",
							m_tuser[0], oldest.ignored, oldest.index));
				end
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(navigate(req_type_t'(s_tuser), s_tdata[1:0],
					s_tdata[CNT_W+1:2]));
			awaiting = expected_q.size();
		end
	end

endmodule

/* bench/image_index_navigator_with_shuffle_core_tb.sv */
// top of the navigator regression: clock, reset, apb set-up, request and result streams
// depends on iinav_pkg, image_index_navigator_with_shuffle_core and iinav_index_checker

module image_index_navigator_with_shuffle_core_tb
	import iinav_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] DIR_REPEAT = 2'b00;
	localparam logic [1:0] DIR_NEXT   = 2'b01;
	localparam logic [1:0] DIR_MINUS2 = 2'b10;
	localparam logic [1:0] DIR_PREV   = 2'b11;

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0] paddr   = '0;
	logic [APB_DATA_W-1:0] pwdata  = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata  = '0;
	logic [1:0]            s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic [0:0]            m_tuser;

	int mismatches;
	int awaiting;

	// effective count and mode as last written, used only to shape the stimulus
	int count_now = 1;
	bit shuffled  = 1'b0;

	int tx_left = 0;
	bit tx_calm = 1'b0;
	int rx_left = 0;
	bit rx_calm = 1'b0;

	image_index_navigator_with_shuffle_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	iinav_index_checker i_index_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic reg_access(input logic wr, input reg_idx_t r, input logic [APB_DATA_W-1:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {r, 2'b00};
		pwdata  <= wr ? v : '0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// write then read back
	task automatic set_reg(input reg_idx_t r, input int v);
		reg_access(1'b1, r, APB_DATA_W'(v));
		reg_access(1'b0, r, '0);
		if (r == REG_COUNT)
			count_now = (v == 0) ? 1 : (v > MAX_IMAGES) ? MAX_IMAGES : v;
		else if (r == REG_RANDOM)
			shuffled = v[0];
	endtask

	task automatic send(input req_type_t kind, input logic [1:0] dir, input int amt);
		int gap;
		if (tx_left == 0) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			tx_left = $urandom_range(10, 60);
		end
		tx_left--;
		gap = tx_calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, CNT_W'(amt), dir};
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and wait for every pending result before touching registers;
	// it waits for a clock edge first so the checker has counted the item accepted last
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (awaiting == 0);
	endtask

	task automatic random_item();
		int sel;
		int share;
		int amt;
		logic [1:0] dir;
		req_type_t kind;
		share = shuffled ? 70 : 45;
		sel   = $urandom_range(0, 99);
		if (sel < share)
			kind = REQ_STEP;
		else
			kind = req_type_t'($urandom_range(1, 3));
		sel = $urandom_range(0, 9);
		dir = (sel < 4) ? DIR_NEXT : (sel < 8) ? DIR_PREV : (sel == 8) ? DIR_REPEAT : DIR_MINUS2;
		case (kind)
			REQ_TO:  amt = ($urandom_range(0, 3) != 0) ? $urandom_range(1, count_now)
				: $urandom_range(0, 8191);
			REQ_STEP: amt = $urandom_range(0, 8191);
			default: amt = ($urandom_range(0, 2) != 0) ? $urandom_range(0, count_now)
				: $urandom_range(0, 8191);
		endcase
		send(kind, dir, amt);
	endtask

	initial begin
		int pick;
		int cnt;
		int large_left;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// single entry after reset: step stays put, only target 1 is in range
		send(REQ_STEP, DIR_NEXT, 0);
		send(REQ_TO, DIR_NEXT, 1);
		send(REQ_TO, DIR_NEXT, 0);
		send(REQ_TO, DIR_NEXT, 2);
		settle();
		set_reg(REG_COUNT, 0);
		send(REQ_STEP, DIR_MINUS2, 0);

		// count above the store depth, zero seed
		settle();
		set_reg(REG_COUNT, 8191);
		set_reg(REG_SEED, 0);
		send(REQ_TO, DIR_NEXT, 4096);
		send(REQ_STEP, DIR_NEXT, 0);
		send(REQ_STEP, DIR_PREV, 0);
		send(REQ_STEP, DIR_REPEAT, 0);
		send(REQ_FWD, DIR_NEXT, 8191);
		send(REQ_BACK, DIR_NEXT, 8191);
		send(REQ_FWD, DIR_NEXT, 5);
		send(REQ_BACK, DIR_NEXT, 2);
		send(REQ_TO, DIR_NEXT, 8191);
		send(REQ_TO, DIR_NEXT, 4000);

		// index left beyond a shrunken count
		settle();
		set_reg(REG_COUNT, 10);
		send(REQ_BACK, DIR_NEXT, 3);
		send(REQ_FWD, DIR_NEXT, 1);
		settle();
		set_reg(REG_COUNT, 4096);
		send(REQ_TO, DIR_NEXT, 4000);
		settle();
		set_reg(REG_COUNT, 10);
		send(REQ_STEP, DIR_NEXT, 0);

		// shuffled order: run the permutation dry, then toggle the mode mid-permutation
		settle();
		set_reg(REG_COUNT, 5);
		set_reg(REG_SEED, 65535);
		set_reg(REG_RANDOM, 1);
		send(REQ_STEP, DIR_NEXT, 0);
		send(REQ_STEP, DIR_PREV, 0);
		send(REQ_STEP, DIR_REPEAT, 0);
		send(REQ_STEP, DIR_NEXT, 0);
		send(REQ_STEP, DIR_NEXT, 0);
		send(REQ_STEP, DIR_NEXT, 0);
		settle();
		set_reg(REG_RANDOM, 0);
		send(REQ_STEP, DIR_NEXT, 0);
		settle();
		set_reg(REG_RANDOM, 1);
		send(REQ_STEP, DIR_NEXT, 0);

		// random phases, mostly small counts so rebuilds stay cheap
		large_left = 3;
		for (int ph = 0; ph < 20; ph++) begin
			settle();
			pick = $urandom_range(0, 19);
			if (pick < 12)
				cnt = $urandom_range(1, 16);
			else if (pick < 17)
				cnt = $urandom_range(17, 300);
			else if (pick < 19 && large_left > 0) begin
				cnt = $urandom_range(301, 8191);
				large_left--;
			end else
				cnt = $urandom_range(0, 1);
			if (ph == 0 || $urandom_range(0, 3) != 0)
				set_reg(REG_COUNT, cnt);
			if ($urandom_range(0, 1) != 0)
				set_reg(REG_RANDOM, $urandom_range(0, 1));
			if ($urandom_range(0, 2) == 0)
				set_reg(REG_SEED, $urandom_range(0, 65535));
			for (int i = 0; i < 100; i++)
				random_item();
		end

		settle();
		repeat (30) @(posedge clk);
		if (mismatches == 0 && awaiting == 0) begin
			$display("image_index_navigator_with_shuffle_core regression: pass");
		end else begin
			$display("image_index_navigator_with_shuffle_core regression: fail");
		end
		$finish;
	end

	// result side back-pressure
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			if (rx_left == 0) begin
				rx_calm = ($urandom_range(0, 3) == 0);
				rx_left = $urandom_range(10, 60);
			end
			rx_left--;
			gap = rx_calm ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		#10_000_000;
		$display("image_index_navigator_with_shuffle_core regression: fail");
		$finish;
	end

endmodule

/* sim.f */
sv/iinav_pkg.sv
sv/iinav_ram.sv
sv/iinav_rem.sv
sv/iinav_seq.sv
sv/image_index_navigator_with_shuffle_core.sv
bench/iinav_index_checker.sv
bench/image_index_navigator_with_shuffle_core_tb.sv
